FILE: rtl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants for the PWM signal-strength pulse decoder.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int LEVEL_W = 16;           // level, widths, seconds
    localparam int LOWEST_W = 7;           // running lowest scaled level
    localparam int QUOT_W = 11;            // scaled quotient never exceeds 1100
    localparam int NUM_W = 23;             // (width - pulse_min) * 100
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_STALE = 16'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_SHORT = 16'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LONG = 16'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_RAW_NEG = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] WIDTH_MARGIN = 16'd10;
    localparam logic [LEVEL_W:0] STALE_SECONDS = 17'd2;
    localparam logic [QUOT_W-1:0] SCALE_FULL = 11'd100;
    localparam logic [QUOT_W-1:0] SCALE_ZERO = 11'd0;
    localparam logic [LOWEST_W-1:0] LOWEST_RESET = 7'd100;

    localparam logic [LEVEL_W-1:0] PULSE_MIN_RESET = 16'd1000;
    localparam logic [LEVEL_W-1:0] PULSE_MAX_RESET = 16'd2000;

    // register indexes on paddr[3:2]
    localparam logic [1:0] REG_PULSE_MIN = 2'd0;
    localparam logic [1:0] REG_PULSE_MAX = 2'd1;
    localparam logic [1:0] REG_RAW_MODE = 2'd2;

    typedef enum logic [1:0] {
        EV_CAPTURE  = 2'd0,
        EV_OVERFLOW = 2'd1,
        EV_RESTART  = 2'd2,
        EV_TIME     = 2'd3
    } event_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCALE,
        S_DIV,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] pulse_min;
        logic [LEVEL_W-1:0] pulse_max;
        logic               raw_mode;
    } cfg_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_res_t;

endpackage

FILE: rtl/prd_cfg_regs.sv
// ----------------------------------------------------------------------------
// prd_cfg_regs
// APB register file: pulse_min, pulse_max and raw_mode.
// ----------------------------------------------------------------------------
module prd_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prd_pkg::ADDR_W-1:0]   paddr,
    input  logic [prd_pkg::DATA_W-1:0]   pwdata,
    output logic [prd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output prd_pkg::cfg_t                cfg
);

    prd_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_min <= prd_pkg::PULSE_MIN_RESET;
            cfg_reg.pulse_max <= prd_pkg::PULSE_MAX_RESET;
            cfg_reg.raw_mode <= 1'b0;
        end else if (wr_en) begin
            case (paddr[3:2])
                prd_pkg::REG_PULSE_MIN: cfg_reg.pulse_min <= pwdata[prd_pkg::LEVEL_W-1:0];
                prd_pkg::REG_PULSE_MAX: cfg_reg.pulse_max <= pwdata[prd_pkg::LEVEL_W-1:0];
                prd_pkg::REG_RAW_MODE:  cfg_reg.raw_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            prd_pkg::REG_PULSE_MIN: prdata = prd_pkg::DATA_W'(cfg_reg.pulse_min);
            prd_pkg::REG_PULSE_MAX: prdata = prd_pkg::DATA_W'(cfg_reg.pulse_max);
            prd_pkg::REG_RAW_MODE:  prdata = prd_pkg::DATA_W'(cfg_reg.raw_mode);
            default:                prdata = '0;
        endcase
    end

endmodule

FILE: rtl/prd_serial_div.sv
// ----------------------------------------------------------------------------
// prd_serial_div
// Restoring divider, one quotient bit per cycle, QUOT_W quotient bits per divide.
// ----------------------------------------------------------------------------
module prd_serial_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [prd_pkg::NUM_W-1:0]     num,
    input  logic [prd_pkg::LEVEL_W-1:0]   den,
    output prd_pkg::div_res_t             res
);

    localparam int DEN_SH_W = prd_pkg::LEVEL_W + prd_pkg::QUOT_W - 1;

    logic [prd_pkg::NUM_W-1:0]  rem_reg;
    logic [DEN_SH_W-1:0]        den_reg;
    logic [prd_pkg::QUOT_W-1:0] quot_reg;
    logic [3:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       fits;

    // caller guarantees the quotient fits in QUOT_W bits
    assign fits = DEN_SH_W'(rem_reg) >= den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 4'(prd_pkg::QUOT_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= {den, {(prd_pkg::QUOT_W - 1){1'b0}}};
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - den_reg[prd_pkg::NUM_W-1:0];
            end
            quot_reg <= {quot_reg[prd_pkg::QUOT_W-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

FILE: rtl/pwm_rssi_pulse_decoder.sv
// ----------------------------------------------------------------------------
// pwm_rssi_pulse_decoder
// Turns rising/falling capture events of a signal-strength PWM pulse into a
// level reading, with raw or scaled output and a staleness timeout.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                                  | tuser
//  ---------+-----------+----------------------------------------+-----------------
//  s_       | in        | [15:0] capture_time, [31:16] now_seconds | [1:0] event_kind
//  m_       | out       | [15:0] level                           | [0] measured
//  APB      | in        | pulse_min @0x0, pulse_max @0x4, raw_mode @0x8
//
//  One item at a time. An item passes through the evaluate, scale and commit
//  states between one accept and the next; a falling edge in range that needs
//  scaling also passes through the divide state, where the serial divider
//  produces one quotient bit per cycle.
//  s_tready returns on the same clock edge that loads the result into the output
//  register, so a new item is taken while a result still waits on m_.
//  A stalled m_ side holds the next item in the commit state.
//  Reset (aresetn low, synchronous) restores the register defaults and the
//  decoder state: waiting for a rising edge, lowest level 100, level 0.
// ----------------------------------------------------------------------------
module pwm_rssi_pulse_decoder #(
    parameter int TIMER_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input transfers
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [15:0] capture_time, [31:16] now_seconds
    input  logic [1:0]                   s_tuser,   // [1:0] event_kind
    // result transfers
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [15:0] level
    output logic [0:0]                   m_tuser,   // [0] measured
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prd_pkg::ADDR_W-1:0]   paddr,
    input  logic [prd_pkg::DATA_W-1:0]   pwdata,
    output logic [prd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    // capture bits actually used: the timer width, at most the field width
    localparam int CAP_W = (TIMER_BITS < prd_pkg::LEVEL_W) ? TIMER_BITS : prd_pkg::LEVEL_W;
    localparam int LW = prd_pkg::LEVEL_W;

    prd_pkg::cfg_t     cfg;
    prd_pkg::div_res_t div_res;
    prd_pkg::state_t   state_reg, state_next;

    // item latched at accept
    prd_pkg::event_kind_t kind_reg;
    logic [CAP_W-1:0]     cap_reg;
    logic [LW-1:0]        now_reg;

    // decoder state
    logic                          phase_reg, phase_next;
    logic [CAP_W-1:0]              rise_reg, rise_next;
    logic [prd_pkg::LOWEST_W-1:0]  lowest_reg, lowest_next;
    logic                          done_reg, done_next;
    logic [LW-1:0]                 lgs_reg, lgs_next;
    logic [LW-1:0]                 level_reg, level_next;

    // classification of the pulse, from the evaluate step
    logic                          fall_reg;
    logic                          neg_reg;
    logic                          below_reg;
    logic                          inr_reg;
    logic [LW-1:0]                 width_reg;
    logic [prd_pkg::QUOT_W-1:0]    scaled_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [LW-1:0]                 m_tdata_reg;
    logic                          m_tuser_reg;

    logic                          accept;
    logic                          div_need;
    logic                          div_start;
    logic                          commit_go;
    logic                          out_free;

    logic                          ev_neg;
    logic [LW-1:0]                 ev_width;
    logic [LW-1:0]                 ev_lo;
    logic [LW:0]                   ev_hi;
    logic                          span_pos;
    logic [prd_pkg::NUM_W-1:0]     div_num;
    logic [prd_pkg::QUOT_W-1:0]    scaled_direct;
    logic [prd_pkg::QUOT_W-1:0]    lowest_ext;

    prd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prd_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (cfg.pulse_max - cfg.pulse_min),
        .res     (div_res)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prd_pkg::S_IDLE:   if (s_tvalid) state_next = prd_pkg::S_EVAL;
            prd_pkg::S_EVAL:   state_next = prd_pkg::S_SCALE;
            prd_pkg::S_SCALE:  state_next = div_need ? prd_pkg::S_DIV : prd_pkg::S_COMMIT;
            prd_pkg::S_DIV:    if (div_res.done) state_next = prd_pkg::S_COMMIT;
            prd_pkg::S_COMMIT: if (out_free) state_next = prd_pkg::S_IDLE;
            default:           state_next = prd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == prd_pkg::S_IDLE);
        div_start = (state_reg == prd_pkg::S_SCALE) && div_need;
        commit_go = (state_reg == prd_pkg::S_COMMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prd_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- evaluate: width and range class ----------------
    always_comb begin
        ev_neg = cap_reg < rise_reg;
        ev_width = LW'(cap_reg - rise_reg);
        // lower bound saturates at zero for a small pulse_min
        ev_lo = (cfg.pulse_min >= prd_pkg::WIDTH_MARGIN) ?
                (cfg.pulse_min - prd_pkg::WIDTH_MARGIN) : '0;
        ev_hi = {1'b0, cfg.pulse_max} + {1'b0, prd_pkg::WIDTH_MARGIN};
    end

    // ---------------- scale: direct cases or start the divider ----------------
    always_comb begin
        span_pos = cfg.pulse_max > cfg.pulse_min;
        div_need = fall_reg && inr_reg && !cfg.raw_mode && span_pos &&
                   (width_reg > cfg.pulse_min);
        div_num = prd_pkg::NUM_W'(width_reg - cfg.pulse_min) *
                  prd_pkg::NUM_W'(prd_pkg::SCALE_FULL);
        if (!span_pos) begin
            scaled_direct = (width_reg > cfg.pulse_min) ? prd_pkg::SCALE_FULL
                                                        : prd_pkg::SCALE_ZERO;
        end else begin
            scaled_direct = prd_pkg::SCALE_ZERO;
        end
    end

    // ---------------- commit: next decoder state ----------------
    always_comb begin
        phase_next = phase_reg;
        rise_next = rise_reg;
        lowest_next = lowest_reg;
        done_next = done_reg;
        lgs_next = lgs_reg;
        level_next = level_reg;
        lowest_ext = prd_pkg::QUOT_W'(lowest_reg);

        if (kind_reg == prd_pkg::EV_RESTART) begin
            done_next = 1'b0;
            lowest_next = prd_pkg::LOWEST_RESET;
            phase_next = 1'b0;
        end else if (!done_reg) begin
            case (kind_reg)
                prd_pkg::EV_OVERFLOW: phase_next = 1'b0;
                prd_pkg::EV_CAPTURE: begin
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                        rise_next = cap_reg;
                    end else begin
                        phase_next = 1'b0;
                        if (inr_reg) begin
                            lgs_next = now_reg;
                            if (!cfg.raw_mode) begin
                                // clamp to the running lowest, else it becomes the lowest
                                if (scaled_reg > lowest_ext) begin
                                    level_next = LW'(lowest_reg);
                                end else begin
                                    lowest_next = scaled_reg[prd_pkg::LOWEST_W-1:0];
                                    level_next = LW'(scaled_reg);
                                end
                                done_next = 1'b1;
                            end
                        end else if (below_reg) begin
                            level_next = prd_pkg::LEVEL_SHORT;
                        end else begin
                            level_next = prd_pkg::LEVEL_LONG;
                        end
                        if (cfg.raw_mode) begin
                            level_next = neg_reg ? prd_pkg::LEVEL_RAW_NEG : width_reg;
                            done_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // stale reading: no good measurement for more than two seconds
        if (({1'b0, lgs_next} + prd_pkg::STALE_SECONDS) < {1'b0, now_reg}) begin
            level_next = prd_pkg::LEVEL_STALE;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            rise_reg <= '0;
            lowest_reg <= prd_pkg::LOWEST_RESET;
            done_reg <= 1'b0;
            lgs_reg <= '0;
            level_reg <= prd_pkg::LEVEL_STALE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (commit_go) begin
                phase_reg <= phase_next;
                rise_reg <= rise_next;
                lowest_reg <= lowest_next;
                done_reg <= done_next;
                lgs_reg <= lgs_next;
                level_reg <= level_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= prd_pkg::event_kind_t'(s_tuser);
            cap_reg <= s_tdata[CAP_W-1:0];
            now_reg <= s_tdata[2*LW-1:LW];
        end
        if (state_reg == prd_pkg::S_EVAL) begin
            fall_reg <= (kind_reg == prd_pkg::EV_CAPTURE) && !done_reg && phase_reg;
            neg_reg <= ev_neg;
            width_reg <= ev_width;
            below_reg <= !ev_neg && (ev_width < ev_lo);
            inr_reg <= !ev_neg && (ev_width >= ev_lo) && ({1'b0, ev_width} <= ev_hi);
        end
        if (state_reg == prd_pkg::S_SCALE) begin
            scaled_reg <= scaled_direct;
        end else if ((state_reg == prd_pkg::S_DIV) && div_res.done) begin
            scaled_reg <= div_res.quot;
        end
        if (commit_go) begin
            m_tdata_reg <= level_next;
            m_tuser_reg <= done_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

FILE: rtl/prd_port_checker.sv
// ----------------------------------------------------------------------------
// prd_port_checker
// Port-level checks on the pulse decoder's transfers, bound to the top level.
// ----------------------------------------------------------------------------
module prd_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // items accepted whose result has not been taken yet
    logic [2:0] open_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_reg + 3'(s_fire) - 3'(m_fire);
        end
    end

    // hold the result while the sink stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time: drop ready right after a transfer in
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second item taken while one is in work");

    // no result without an item behind it
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_reg != 3'd0)
        else $error("result without an accepted item");

    // at most one item in work and one result waiting
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= 3'd2)
        else $error("too many items outstanding");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pwm_rssi_pulse_decoder prd_port_checker u_prd_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/pwm_rssi_pulse_decoder_test.sv
// ----------------------------------------------------------------------------
// pwm_rssi_pulse_decoder_test
// Drives capture, overflow, restart and time-update events into the pulse
// decoder, predicts every reading with a cycle-free model of the decoder and
// checks each result transfer in order. Directed cases cover the range edges,
// raw mode, the staleness timeout and non-positive spans; random pulse
// sequences follow under several register settings, with random bursts on
// the input, random stalls on the output and one long output hold-off.
// ----------------------------------------------------------------------------
module pwm_rssi_pulse_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] level;
        logic        measured;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;       // [15:0] capture_time, [31:16] now_seconds
    logic [1:0]  s_tuser;       // [1:0] event_kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;       // [15:0] level
    logic [0:0]  m_tuser;       // [0] measured
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [prd_pkg::ADDR_W-1:0] paddr;
    logic [prd_pkg::DATA_W-1:0] pwdata;
    logic [prd_pkg::DATA_W-1:0] prdata;
    logic        pready;

    pwm_rssi_pulse_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Decoder prediction: register copies and decoder state
    // ------------------------------------------------------------------------
    logic [15:0] pmin;
    logic [15:0] pmax;
    logic        praw;

    logic        awaiting_fall;     // rising edge seen, falling edge pending
    logic [15:0] rise_t;
    int unsigned lowest;
    logic        done;
    logic [15:0] last_good;
    logic [15:0] level_now;

    reading_t    readings_due[$];   // expected readings, oldest first
    reading_t    got_rd;
    reading_t    want_rd;
    int          mismatch_count;
    int          items_sent;

    // Pacing of both sides
    bit          steady;            // no gaps on input, no stalls on output
    int          burst_left;
    int          hold_req;          // long output hold-off, picked up below
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    logic [15:0] now_s;             // running flight time used by random traffic

    // Advance the predicted decoder by one event and return the reading.
    function automatic void decode_event(input prd_pkg::event_kind_t kind,
                                         input logic [15:0] cap,
                                         input logic [15:0] now,
                                         output reading_t rd);
        bit negative;
        bit in_range;
        int unsigned width;
        int unsigned lo;
        int unsigned hi;
        int unsigned scaled;
        if (kind == prd_pkg::EV_RESTART) begin
            done = 1'b0;
            lowest = 100;
            awaiting_fall = 1'b0;
        end else if (!done) begin
            if (kind == prd_pkg::EV_OVERFLOW) begin
                awaiting_fall = 1'b0;
            end else if (kind == prd_pkg::EV_CAPTURE && !awaiting_fall) begin
                awaiting_fall = 1'b1;
                rise_t = cap;
            end else if (kind == prd_pkg::EV_CAPTURE) begin
                // falling edge: measure the pulse
                awaiting_fall = 1'b0;
                negative = cap < rise_t;
                width = negative ? 0 : int'(cap) - int'(rise_t);
                lo = (pmin >= 10) ? int'(pmin) - 10 : 0;
                hi = int'(pmax) + 10;
                in_range = !negative && width >= lo && width <= hi;
                if (in_range) begin
                    last_good = now;
                    if (!praw) begin
                        if (pmax <= pmin)
                            scaled = (width > pmin) ? 100 : 0;
                        else if (width <= pmin)
                            scaled = 0;
                        else
                            scaled = (width - pmin) * 100 / (pmax - pmin);
                        // clamp to the running lowest, or lower it
                        if (scaled > lowest)
                            scaled = lowest;
                        else
                            lowest = scaled;
                        done = 1'b1;
                        level_now = scaled[15:0];
                    end
                end else if (!negative && width < lo) begin
                    level_now = prd_pkg::LEVEL_SHORT;
                end else begin
                    level_now = prd_pkg::LEVEL_LONG;
                end
                if (praw) begin
                    level_now = negative ? prd_pkg::LEVEL_RAW_NEG : width[15:0];
                    done = 1'b1;
                end
            end
        end
        // staleness, compared without wrap
        if ({1'b0, last_good} + 17'd2 < {1'b0, now})
            level_now = prd_pkg::LEVEL_STALE;
        rd.level = level_now;
        rd.measured = done;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------------
    always #2 aclk = ~aclk;

    // End the run if traffic stops making progress.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------------
    // Stall in short random runs; a long hold-off is counted here once asked.
    always @(negedge aclk) begin
        if (hold_req != 0 && !hold_taken) begin
            hold_left = hold_req;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest expected reading.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rd.level = m_tdata;
            got_rd.measured = m_tuser[0];
            if (readings_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result, level %0d", got_rd.level));
            end else begin
                want_rd = readings_due.pop_front();
                if (got_rd.level !== want_rd.level)
                    report_mismatch($sformatf("level %0d, expected %0d",
                                              got_rd.level, want_rd.level));
                if (got_rd.measured !== want_rd.measured)
                    report_mismatch($sformatf("measured %0b, expected %0b",
                                              got_rd.measured, want_rd.measured));
            end
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one event, wait for its transfer, record the expected reading,
    // then either hold valid for the next event of the burst or idle a while.
    task automatic send_event(input prd_pkg::event_kind_t kind, input logic [15:0] cap,
                              input logic [15:0] now);
        reading_t rd;
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {now, cap};
        do @(posedge aclk); while (!s_tready);
        decode_event(kind, cap, now, rd);
        readings_due.push_back(rd);
        items_sent++;
        if (!steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 10);
                gap = $urandom_range(1, 6);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Drop valid and wait until every expected reading has arrived.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (readings_due.size() != 0) @(posedge aclk);
    endtask

    // Write one register (setup and access phase), then read it back.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            prd_pkg::REG_PULSE_MIN: begin
                pmin = value[15:0];
                mask = 32'h0000_FFFF;
            end
            prd_pkg::REG_PULSE_MAX: begin
                pmax = value[15:0];
                mask = 32'h0000_FFFF;
            end
            default: begin
                praw = value[0];
                mask = 32'h0000_0001;
            end
        endcase
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if ((prdata & mask) !== (value & mask))
            report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      idx, prdata & mask, value & mask));
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reprogram all three registers once the decoder has gone idle.
    task automatic apply_settings(input int unsigned lo_w, input int unsigned hi_w,
                                  input bit raw);
        drain();
        write_register(prd_pkg::REG_PULSE_MIN, lo_w);
        write_register(prd_pkg::REG_PULSE_MAX, hi_w);
        write_register(prd_pkg::REG_RAW_MODE, 32'(raw));
    endtask

    // Step the flight time: mostly steady, sometimes a jump, rarely anywhere.
    function automatic logic [15:0] next_now();
        case ($urandom_range(0, 19))
            0:       now_s = 16'($urandom_range(0, 65535));
            1, 2:    now_s = now_s + 16'($urandom_range(2, 6));
            default: now_s = now_s + 16'($urandom_range(0, 1));
        endcase
        return now_s;
    endfunction

    // One rising/falling pair, usually after a restart, with a width drawn
    // around the current window; sometimes broken by an overflow.
    task automatic send_random_pulse();
        int unsigned lo;
        int unsigned hi;
        int unsigned width;
        int unsigned base;
        int pick;
        logic [15:0] rise;
        logic [15:0] fall;
        lo = (pmin >= 10) ? int'(pmin) - 10 : 0;
        hi = (int'(pmax) + 10 > 65535) ? 65535 : int'(pmax) + 10;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3, 4: width = $urandom_range(lo, hi);
            5, 6: begin
                case ($urandom_range(0, 3))
                    0:       base = lo;
                    1:       base = hi;
                    2:       base = int'(pmin);
                    default: base = int'(pmax);
                endcase
                width = base + $urandom_range(0, 6);
                width = (width < 3) ? 0 : width - 3;
                if (width > 65535)
                    width = 65535;
            end
            7:       width = $urandom_range(0, lo);
            default: width = $urandom_range(0, 65535);
        endcase
        rise = 16'($urandom_range(0, 65535));
        fall = rise + width[15:0];
        if (pick == 9) begin
            // falling capture earlier than the rising one
            rise = 16'($urandom_range(1, 65535));
            fall = 16'($urandom_range(0, rise - 1));
        end
        if ($urandom_range(0, 2) != 0)
            send_event(prd_pkg::EV_RESTART, 16'($urandom_range(0, 65535)), next_now());
        if ($urandom_range(0, 7) == 0)
            send_event(prd_pkg::EV_OVERFLOW, 16'($urandom_range(0, 65535)), next_now());
        send_event(prd_pkg::EV_CAPTURE, rise, next_now());
        if ($urandom_range(0, 5) == 0)
            send_event(prd_pkg::EV_TIME, 16'($urandom_range(0, 65535)), next_now());
        if ($urandom_range(0, 11) == 0)
            send_event(prd_pkg::EV_OVERFLOW, 16'($urandom_range(0, 65535)), next_now());
        send_event(prd_pkg::EV_CAPTURE, fall, next_now());
        if ($urandom_range(0, 3) == 0)
            send_event(prd_pkg::EV_TIME, 16'($urandom_range(0, 65535)), next_now());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Register defaults (1000..2000, scaled): edges, range limits, staleness.
    task automatic test_defaults();
        send_event(prd_pkg::EV_TIME, 16'd0, 16'd0);         // nothing measured yet
        send_event(prd_pkg::EV_CAPTURE, 16'd100, 16'd0);
        send_event(prd_pkg::EV_CAPTURE, 16'd1600, 16'd1);   // mid scale
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd1);      // ignored after done
        send_event(prd_pkg::EV_OVERFLOW, 16'hFFFF, 16'd1);  // ignored after done
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd1);
        send_event(prd_pkg::EV_CAPTURE, 16'hFFFF, 16'd1);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd1);      // falls before it rose
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd2);
        send_event(prd_pkg::EV_CAPTURE, 16'd500, 16'd2);    // too short
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd2);
        send_event(prd_pkg::EV_CAPTURE, 16'd3000, 16'd2);   // too long
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd2);
        send_event(prd_pkg::EV_OVERFLOW, 16'd0, 16'd2);     // drop the rising edge
        send_event(prd_pkg::EV_CAPTURE, 16'd1500, 16'd3);
        send_event(prd_pkg::EV_CAPTURE, 16'd3300, 16'd3);   // width 1800
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd3);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd3);
        send_event(prd_pkg::EV_CAPTURE, 16'd995, 16'd4);    // below min, in window
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd4);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd4);
        send_event(prd_pkg::EV_CAPTURE, 16'd2010, 16'd5);   // scaled above lowest
        send_event(prd_pkg::EV_TIME, 16'd0, 16'd8);         // goes stale
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'hFFFF);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'hFFFF);
        send_event(prd_pkg::EV_CAPTURE, 16'd1000, 16'hFFFF);
        send_event(prd_pkg::EV_TIME, 16'hFFFF, 16'hFFFF);   // fresh at the top
    endtask

    // Widest window, then spans that are zero or negative.
    task automatic test_config_extremes();
        apply_settings(10, 65525, 1'b0);
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd10);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd10);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd10);     // zero width in window
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd10);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd10);
        send_event(prd_pkg::EV_CAPTURE, 16'hFFFF, 16'd11);  // full timer width
        apply_settings(1500, 1500, 1'b0);
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd11);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd11);
        send_event(prd_pkg::EV_CAPTURE, 16'd1500, 16'd11);
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd11);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd11);
        send_event(prd_pkg::EV_CAPTURE, 16'd1505, 16'd12);
        apply_settings(1500, 1495, 1'b0);
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd12);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd12);
        send_event(prd_pkg::EV_CAPTURE, 16'd1503, 16'd12);
        apply_settings(65525, 10, 1'b0);
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd12);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd12);
        send_event(prd_pkg::EV_CAPTURE, 16'd20, 16'd12);
    endtask

    // Raw widths: in range, short, long and negative.
    task automatic test_raw_mode();
        apply_settings(1000, 2000, 1'b1);
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd20);
        send_event(prd_pkg::EV_CAPTURE, 16'd7, 16'd20);
        send_event(prd_pkg::EV_CAPTURE, 16'd1507, 16'd20);
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd21);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd21);
        send_event(prd_pkg::EV_CAPTURE, 16'd50, 16'd22);    // short, no refresh
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd23);
        send_event(prd_pkg::EV_CAPTURE, 16'd0, 16'd23);
        send_event(prd_pkg::EV_CAPTURE, 16'd40000, 16'd23);
        send_event(prd_pkg::EV_RESTART, 16'd0, 16'd23);
        send_event(prd_pkg::EV_CAPTURE, 16'd9, 16'd23);
        send_event(prd_pkg::EV_CAPTURE, 16'd8, 16'd23);     // negative width
        send_event(prd_pkg::EV_TIME, 16'd0, 16'd30);
    endtask

    // Hold the result side off for a long stretch while events keep coming,
    // so the decoder fills up and stalls its input.
    task automatic test_receiver_hold();
        apply_settings(1000, 2000, 1'b0);
        hold_req = 300;
        repeat (12) send_random_pulse();
        drain();
    endtask

    // Pause the sender until every result is in, then carry on.
    task automatic test_drain_pause();
        repeat (4) send_random_pulse();
        drain();
        repeat (4) send_random_pulse();
    endtask

    // Random pulses and noise under a series of register settings.
    task automatic test_random_traffic();
        int unsigned lo_w;
        int unsigned hi_w;
        int target;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin lo_w = 1000;  hi_w = 2000;  end
                1: begin lo_w = 10;    hi_w = 65525; end
                2: begin lo_w = 500;   hi_w = 510;   end
                3: begin lo_w = 3000;  hi_w = 2985;  end
                4: begin lo_w = 65525; hi_w = 65525; end
                default: begin
                    lo_w = $urandom_range(10, 40000);
                    hi_w = lo_w + $urandom_range(1, 25525);
                end
            endcase
            apply_settings(lo_w, hi_w, phase == 1 || phase == 6);
            steady = (phase == 5);
            target = items_sent + 40;
            while (items_sent < target) begin
                if ($urandom_range(0, 6) == 0)
                    send_event(prd_pkg::event_kind_t'($urandom_range(0, 3)),
                               16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)));
                else
                    send_random_pulse();
            end
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        // predicted state after reset
        pmin = prd_pkg::PULSE_MIN_RESET;
        pmax = prd_pkg::PULSE_MAX_RESET;
        praw = 1'b0;
        awaiting_fall = 1'b0;
        rise_t = '0;
        lowest = 100;
        done = 1'b0;
        last_good = '0;
        level_now = '0;
        mismatch_count = 0;
        items_sent = 0;
        steady = 1'b0;
        burst_left = 0;
        hold_req = 0;
        now_s = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_config_extremes();
        test_raw_mode();
        test_receiver_hold();
        test_drain_pause();
        test_random_traffic();

        // let every reading arrive, then watch for strays
        drain();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: pwm_rssi_pulse_decoder.f
rtl/prd_pkg.sv
rtl/prd_cfg_regs.sv
rtl/prd_serial_div.sv
rtl/pwm_rssi_pulse_decoder.sv
rtl/prd_port_checker.sv
bench/pwm_rssi_pulse_decoder_test.sv
